@@ sv/swm_pkg.sv @@
package swm_pkg;

    localparam int SAMPLE_W       = 30;
    localparam int LEN_W          = 11;
    localparam int MAX_WINDOW_DEF = 1024;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

    // partial window extremes handed from cell to cell
    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] hi;
        logic [SAMPLE_W-1:0] lo;
    } scan_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

endpackage

@@ sv/swm_if.sv @@
interface swm_in_if;
    logic                         valid;
    logic                         ready;
    logic [swm_pkg::SAMPLE_W-1:0] sample;
    logic                         case_end;

    modport source (output valid, output sample, output case_end, input ready);
    modport sink   (input valid, input sample, input case_end, output ready);
endinterface

interface swm_out_if;
    logic                         valid;
    logic                         ready;
    logic [swm_pkg::SAMPLE_W-1:0] best_spread;

    modport source (output valid, output best_spread, input ready);
    modport sink   (input valid, input best_spread, output ready);
endinterface

@@ sv/swm_cell.sv @@
module swm_cell #(
    parameter int CNT_W = 11
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         shift_en,
    input  logic [swm_pkg::SAMPLE_W-1:0] sample_in,
    output logic [swm_pkg::SAMPLE_W-1:0] sample_out,
    input  swm_pkg::scan_t               scan_in,
    input  logic [CNT_W-1:0]             rem_in,
    output swm_pkg::scan_t               scan_out,
    output logic [CNT_W-1:0]             rem_out
);

    logic [swm_pkg::SAMPLE_W-1:0] sample_reg;
    logic                         valid_reg;
    logic [swm_pkg::SAMPLE_W-1:0] hi_reg;
    logic [swm_pkg::SAMPLE_W-1:0] lo_reg;
    swm_pkg::scan_t               scan_next;
    logic [CNT_W-1:0]             rem_reg;
    logic [CNT_W-1:0]             rem_next;
    logic                         take;

    // this cell's sample belongs to the window while the countdown is nonzero
    assign take = (rem_in != '0);

    always_comb
    begin
        scan_next.valid = scan_in.valid;
        scan_next.hi    = (take && (sample_reg > scan_in.hi)) ? sample_reg : scan_in.hi;
        scan_next.lo    = (take && (sample_reg < scan_in.lo)) ? sample_reg : scan_in.lo;
        rem_next        = take ? (rem_in - CNT_W'(1)) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            sample_reg <= sample_in;
        end
        hi_reg  <= scan_next.hi;
        lo_reg  <= scan_next.lo;
        rem_reg <= rem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= scan_next.valid;
        end
    end

    assign sample_out = sample_reg;
    assign scan_out   = {valid_reg, hi_reg, lo_reg};
    assign rem_out    = rem_reg;

endmodule

@@ sv/sliding_window_max_spread.sv @@
// Channel     Modport  Payload                     Transaction when
// sample_ch   sink     sample[29:0], case_end      valid & ready at clk rise
// result_ch   source   best_spread[29:0]           valid & ready at clk rise
// cfg         write    cfg_wdata[10:0] (window)    cfg_we at clk rise
//
// A sample that does not complete a full window needs no scan.
// A sample that completes a window first launches the scan packet, which walks the whole
// cell chain, one cell per cycle, and is then folded into the best spread, before the next
// sample is taken.
// rst_n is asynchronous, active low; it clears control state and sets window to 1.
// A waiting result holds sample_ch.ready low only until result_ch takes it.
module sliding_window_max_spread #(
    parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [swm_pkg::LEN_W-1:0] cfg_wdata,
    swm_in_if.sink                    sample_ch,
    swm_out_if.source                 result_ch
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    // configuration
    logic [swm_pkg::LEN_W-1:0] window_len_reg;
    logic [CNT_W-1:0]          len_eff;

    // control
    swm_pkg::state_t              state_reg, state_next;
    logic [CNT_W-1:0]             seen_count_reg, seen_count_next;
    logic [swm_pkg::SAMPLE_W-1:0] running_best_reg, running_best_next;
    logic                         launch_reg, launch_next;
    logic                         last_reg, last_next;
    logic                         out_valid_reg, out_valid_next;
    logic [swm_pkg::SAMPLE_W-1:0] out_data_reg, out_data_next;

    logic                         accept;
    logic [CNT_W-1:0]             seen_inc;
    logic [swm_pkg::SAMPLE_W-1:0] spread;
    logic [swm_pkg::SAMPLE_W-1:0] best_upd;

    // cell chain wiring
    logic [swm_pkg::SAMPLE_W-1:0] samp_q [0:MAX_WINDOW-1];
    swm_pkg::scan_t               scan_q [0:MAX_WINDOW];
    logic [CNT_W-1:0]             rem_q  [0:MAX_WINDOW];

    // zero means 1, anything above the chain length means the chain length
    always_comb
    begin
        priority if (window_len_reg == '0)
            len_eff = CNT_W'(1);
        else if (32'(window_len_reg) > 32'(MAX_WINDOW))
            len_eff = CNT_W'(MAX_WINDOW);
        else
            len_eff = CNT_W'(window_len_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= swm_pkg::LEN_RESET;
        end
        else if (cfg_we)
        begin
            window_len_reg <= cfg_wdata;
        end
    end

    // Scan packet enters cell 0 the cycle after the sample is shifted in.
    // The countdown tells each cell whether its sample is inside the window.
    assign scan_q[0].valid = launch_reg;
    assign scan_q[0].hi    = '0;
    assign scan_q[0].lo    = '1;
    assign rem_q[0]        = len_eff;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_WINDOW; gi++)
        begin : g_cell
            if (gi == MAX_WINDOW - 1)
            begin : g_tail
                swm_cell #(.CNT_W(CNT_W)) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .shift_en   (accept),
                    .sample_in  ((gi == 0) ? sample_ch.sample : samp_q[(gi == 0) ? 0 : gi-1]),
                    .sample_out (samp_q[gi]),
                    .scan_in    (scan_q[gi]),
                    .rem_in     (rem_q[gi]),
                    .scan_out   (scan_q[gi+1]),
                    .rem_out    (rem_q[gi+1])
                );
            end
            else
            begin : g_body
                swm_cell #(.CNT_W(CNT_W)) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .shift_en   (accept),
                    .sample_in  ((gi == 0) ? sample_ch.sample : samp_q[(gi == 0) ? 0 : gi-1]),
                    .sample_out (samp_q[gi]),
                    .scan_in    (scan_q[gi]),
                    .rem_in     (rem_q[gi]),
                    .scan_out   (scan_q[gi+1]),
                    .rem_out    (rem_q[gi+1])
                );
            end
        end
    endgenerate

    // one sample at a time; a held result blocks only until it is taken
    assign sample_ch.ready = (state_reg == swm_pkg::ST_IDLE) && !launch_reg
                             && (!out_valid_reg || result_ch.ready);
    assign accept          = sample_ch.valid && sample_ch.ready;

    assign seen_inc = (seen_count_reg == CNT_W'(MAX_WINDOW)) ? seen_count_reg
                                                             : seen_count_reg + CNT_W'(1);
    assign spread   = scan_q[MAX_WINDOW].hi - scan_q[MAX_WINDOW].lo;
    assign best_upd = (spread > running_best_reg) ? spread : running_best_reg;

    always_comb
    begin
        state_next        = state_reg;
        seen_count_next   = seen_count_reg;
        running_best_next = running_best_reg;
        launch_next       = 1'b0;
        last_next         = last_reg;
        out_valid_next    = out_valid_reg && !result_ch.ready;
        out_data_next     = out_data_reg;

        unique case (state_reg)
            swm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    seen_count_next = seen_inc;
                    if (seen_inc >= len_eff)
                    begin
                        // full window: walk the chain before finishing the sample
                        launch_next = 1'b1;
                        last_next   = sample_ch.case_end;
                        state_next  = swm_pkg::ST_SCAN;
                    end
                    else if (sample_ch.case_end)
                    begin
                        out_valid_next    = 1'b1;
                        out_data_next     = running_best_reg;
                        running_best_next = '0;
                        seen_count_next   = '0;
                    end
                end
            end
            swm_pkg::ST_SCAN:
            begin
                if (scan_q[MAX_WINDOW].valid)
                begin
                    state_next        = swm_pkg::ST_IDLE;
                    running_best_next = best_upd;
                    if (last_reg)
                    begin
                        out_valid_next    = 1'b1;
                        out_data_next     = best_upd;
                        running_best_next = '0;
                        seen_count_next   = '0;
                    end
                end
            end
            default:
            begin
                state_next = swm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= swm_pkg::ST_IDLE;
            seen_count_reg   <= '0;
            running_best_reg <= '0;
            launch_reg       <= 1'b0;
            last_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            seen_count_reg   <= seen_count_next;
            running_best_reg <= running_best_next;
            launch_reg       <= launch_next;
            last_reg         <= last_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign result_ch.valid       = out_valid_reg;
    assign result_ch.best_spread = out_data_reg;

    // the scan packet only leaves the chain while the controller waits for it
    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_q[MAX_WINDOW].valid |-> (state_reg == swm_pkg::ST_SCAN))
        else $error("scan packet left the chain outside a scan");

    // a scan is only started once enough samples are held for a full window
    a_launch_full: assert property (@(posedge clk) disable iff (!rst_n)
        launch_reg |-> (seen_count_reg >= len_eff))
        else $error("scan launched without a full window");

    // sample count saturates at the chain length
    a_seen_sat: assert property (@(posedge clk) disable iff (!rst_n)
        32'(seen_count_reg) <= 32'(MAX_WINDOW))
        else $error("seen count above chain length");

    // a new result only follows a case-end sample
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg && !result_ch.ready))
            |-> ($past(last_reg) || $past(accept && sample_ch.case_end)))
        else $error("result raised without a case end");

endmodule
